// ----- hdl/string_to_integer_parser_defines.svh -----
// Assertion macros for the string to integer parser.
// Included by the top level; expects signals clk and rst in scope.
`ifndef STRING_TO_INTEGER_PARSER_DEFINES_SVH
`define STRING_TO_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define S2I_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define S2I_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/s2i_pkg.sv -----
// Shared types and constants of the string to integer parser.
// Used by every module of the block but s2i_queue; depends on nothing.
package s2i_pkg;

  localparam int CH_W            = 8;
  localparam int BASE_W          = 6;
  localparam int VALUE_W         = 64;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = BASE_W;
  localparam int OFFSET_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] DEC_BASE   = BASE_W'(10);
  localparam logic [BASE_W-1:0] OCT_BASE   = BASE_W'(8);
  localparam logic [BASE_W-1:0] HEX_BASE   = BASE_W'(16);
  localparam logic [BASE_W-1:0] MAX_BASE   = BASE_W'(36);
  localparam logic [BASE_W-1:0] AUTO_BASE  = BASE_W'(0);
  localparam logic [BASE_W-1:0] BAD_BASE   = BASE_W'(1);

  localparam logic [VALUE_W-1:0] ALL_ONES  = {VALUE_W{1'b1}};
  localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_BASE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MODE = 1'b1;

  // Parse phases of one string.
  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_XPFX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // One character after classification by the front end.
  typedef struct packed {
    logic              last;
    logic              is_space;
    logic              is_minus;
    logic              is_plus;
    logic              is_zero;
    logic              is_x;
    logic              is_alnum;
    logic [BASE_W-1:0] digit;
  } class_t;

  // Final parse state of one string, handed to the result stage.
  typedef struct packed {
    logic [VALUE_W-1:0] magnitude;
    logic               is_negative;
    logic               saturated;
    logic               any_digit;
    logic               signed_mode;
  } summary_t;

endpackage

// ----- hdl/s2i_queue.sv -----
// Small first-in first-out queue built from registers.
// Generic; depends on nothing but its parameters.
module s2i_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (ADDR_W+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage is written at the tail; it needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap at the depth; the count tells full from empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/s2i_front.sv -----
// Front end: classifies each incoming character for the parse engine.
// Depends on s2i_pkg for the class word layout.
module s2i_front (
  input  logic [s2i_pkg::CH_W-1:0] ch,
  input  logic                     last,
  output s2i_pkg::class_t          cls
);
  import s2i_pkg::*;

  // Decode whitespace, sign, prefix characters and the digit value.
  always_comb begin
    cls          = '0;
    cls.last     = last;
    cls.is_space = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    cls.is_minus = (ch == 8'h2D);
    cls.is_plus  = (ch == 8'h2B);
    cls.is_zero  = (ch == 8'h30);
    cls.is_x     = (ch == 8'h78) || (ch == 8'h58);
    if ((ch >= 8'h30) && (ch <= 8'h39)) begin
      cls.is_alnum = 1'b1;
      cls.digit    = BASE_W'(ch - 8'h30);
    end else if ((ch >= 8'h61) && (ch <= 8'h7A)) begin
      cls.is_alnum = 1'b1;
      cls.digit    = BASE_W'(ch - 8'h57);
    end else if ((ch >= 8'h41) && (ch <= 8'h5A)) begin
      cls.is_alnum = 1'b1;
      cls.digit    = BASE_W'(ch - 8'h37);
    end
  end

endmodule

// ----- hdl/s2i_back.sv -----
// Parse engine: runs the phase machine and the digit accumulator.
// Depends on s2i_pkg for the phase, class and summary types.
module s2i_back #(
  parameter int OFFSET_BITS = s2i_pkg::OFFSET_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  input  s2i_pkg::class_t            cls,
  input  logic                       stall,
  input  logic [s2i_pkg::BASE_W-1:0] number_base,
  input  logic                       signed_mode,
  output logic                       take,
  output logic                       done,
  output s2i_pkg::summary_t          summary,
  output logic [OFFSET_BITS-1:0]     end_pos
);
  import s2i_pkg::*;

  localparam int PROD_W = VALUE_W + BASE_W;

  phase_t               phase;
  phase_t               phase_next;
  logic                 is_negative;
  logic                 is_negative_next;
  logic [VALUE_W-1:0]   magnitude;
  logic [VALUE_W-1:0]   magnitude_next;
  logic [BASE_W-1:0]    active_base;
  logic [BASE_W-1:0]    active_base_next;
  logic [OFFSET_BITS-1:0] char_position;
  logic [OFFSET_BITS-1:0] char_position_next;
  logic [OFFSET_BITS-1:0] digit_end;
  logic [OFFSET_BITS-1:0] digit_end_next;
  logic                 saturated;
  logic                 saturated_next;
  logic                 any_digit;
  logic                 any_digit_next;

  logic              start_sel;
  logic              base_bad;
  logic              zero_pfx;
  logic [BASE_W-1:0] start_base;
  logic              dig_ok_start;
  logic              dig_ok_active;
  logic              acc_en;
  logic [BASE_W-1:0] acc_base;
  logic [PROD_W-1:0] prod;
  logic              prod_ovf;

  assign take = valid && !stall;
  assign done = take && cls.last;

  // Decisions shared by the phase machine and the datapath.
  always_comb begin
    start_sel     = ((phase == PH_SPACE) && !cls.is_space && !cls.is_minus
                     && !cls.is_plus) || (phase == PH_SIGN);
    base_bad      = (number_base == BAD_BASE) || (number_base > MAX_BASE);
    zero_pfx      = ((number_base == AUTO_BASE) || (number_base == HEX_BASE))
                    && cls.is_zero;
    start_base    = (number_base == AUTO_BASE) ? DEC_BASE : number_base;
    dig_ok_start  = cls.is_alnum && (cls.digit < start_base);
    dig_ok_active = cls.is_alnum && (cls.digit < active_base);
  end

  // Next phase of the parse; the closing character restarts it.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SPACE, PH_SIGN: begin
        if ((phase == PH_SPACE) && cls.is_space) begin
          phase_next = PH_SPACE;
        end else if ((phase == PH_SPACE) && (cls.is_minus || cls.is_plus)) begin
          phase_next = PH_SIGN;
        end else if (base_bad) begin
          phase_next = PH_DONE;
        end else if (zero_pfx) begin
          phase_next = PH_ZERO;
        end else begin
          phase_next = dig_ok_start ? PH_DIGITS : PH_DONE;
        end
      end
      PH_ZERO: begin
        if (cls.is_x) begin
          phase_next = PH_XPFX;
        end else begin
          phase_next = dig_ok_active ? PH_DIGITS : PH_DONE;
        end
      end
      PH_XPFX, PH_DIGITS: begin
        phase_next = dig_ok_active ? PH_DIGITS : PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
    if (cls.last) begin
      phase_next = PH_SPACE;
    end
  end

  // One multiply-add by the radix per character, with overflow detect.
  always_comb begin
    acc_base = start_sel ? start_base : active_base;
    acc_en   = (start_sel && !base_bad && !zero_pfx && dig_ok_start)
               || ((((phase == PH_ZERO) && !cls.is_x) || (phase == PH_XPFX)
                    || (phase == PH_DIGITS)) && dig_ok_active);
    prod     = PROD_W'(magnitude) * PROD_W'(acc_base) + PROD_W'(cls.digit);
    prod_ovf = |prod[PROD_W-1:VALUE_W];
  end

  // Datapath updates for the accepted character.
  always_comb begin
    char_position_next = (&char_position) ? char_position : char_position + 1'b1;
    is_negative_next   = is_negative;
    magnitude_next     = magnitude;
    active_base_next   = active_base;
    digit_end_next     = digit_end;
    saturated_next     = saturated;
    any_digit_next     = any_digit;
    if ((phase == PH_SPACE) && cls.is_minus) begin
      is_negative_next = 1'b1;
    end
    if (start_sel && !base_bad) begin
      if (zero_pfx) begin
        active_base_next = (number_base == AUTO_BASE) ? OCT_BASE : HEX_BASE;
        any_digit_next   = 1'b1;
        digit_end_next   = char_position_next;
      end else begin
        active_base_next = start_base;
      end
    end
    if ((phase == PH_ZERO) && cls.is_x) begin
      active_base_next = HEX_BASE;
    end
    if (acc_en) begin
      magnitude_next = prod_ovf ? ALL_ONES : prod[VALUE_W-1:0];
      saturated_next = saturated || prod_ovf;
      any_digit_next = 1'b1;
      digit_end_next = char_position_next;
    end
  end

  // Final state of the string goes to the result stage.
  always_comb begin
    summary.magnitude   = magnitude_next;
    summary.is_negative = is_negative_next;
    summary.saturated   = saturated_next;
    summary.any_digit   = any_digit_next;
    summary.signed_mode = signed_mode;
    end_pos             = digit_end_next;
  end

  // Parse state; cleared by reset and after every closing character.
  always_ff @(posedge clk) begin
    if (rst || done) begin
      phase         <= PH_SPACE;
      is_negative   <= 1'b0;
      magnitude     <= '0;
      active_base   <= '0;
      char_position <= '0;
      digit_end     <= '0;
      saturated     <= 1'b0;
      any_digit     <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      is_negative   <= is_negative_next;
      magnitude     <= magnitude_next;
      active_base   <= active_base_next;
      char_position <= char_position_next;
      digit_end     <= digit_end_next;
      saturated     <= saturated_next;
      any_digit     <= any_digit_next;
    end
  end

endmodule

// ----- hdl/s2i_finish.sv -----
// Result stage: applies sign, saturation and clamping to a parsed string.
// Depends on s2i_pkg for the summary type and limit constants.
module s2i_finish #(
  parameter int OFFSET_BITS = s2i_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  s2i_pkg::summary_t      summary,
  input  logic [OFFSET_BITS-1:0] end_pos,
  input  logic                   out_full,
  output logic                   hold,
  output logic                   push,
  output logic [s2i_pkg::VALUE_W+OFFSET_BITS+1:0] word
);
  import s2i_pkg::*;

  logic                   fin_valid;
  summary_t               sum_q;
  logic [OFFSET_BITS-1:0] end_q;
  logic [VALUE_W-1:0]     neg_mag;
  logic [VALUE_W-1:0]     value;
  logic                   overflowed;

  assign hold = fin_valid && out_full;
  assign push = fin_valid && !out_full;

  // The stage holds one string until the result queue takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else begin
      fin_valid <= load || hold;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_q <= summary;
      end_q <= end_pos;
    end
  end

  // Select the value: plain, negated, all ones, or a signed limit.
  always_comb begin
    neg_mag    = (~sum_q.magnitude) + 1'b1;
    value      = '0;
    overflowed = 1'b0;
    if (!sum_q.any_digit) begin
      value = '0;
    end else if (sum_q.signed_mode) begin
      if (sum_q.is_negative) begin
        if (sum_q.saturated || (sum_q.magnitude[VALUE_W-1]
                                && |sum_q.magnitude[VALUE_W-2:0])) begin
          value      = NEG_LIMIT;
          overflowed = 1'b1;
        end else begin
          value = neg_mag;
        end
      end else begin
        if (sum_q.saturated || sum_q.magnitude[VALUE_W-1]) begin
          value      = POS_LIMIT;
          overflowed = 1'b1;
        end else begin
          value = sum_q.magnitude;
        end
      end
    end else begin
      if (sum_q.saturated) begin
        value      = ALL_ONES;
        overflowed = 1'b1;
      end else begin
        value = sum_q.is_negative ? neg_mag : sum_q.magnitude;
      end
    end
  end

  assign word = {value, (sum_q.any_digit ? end_q : {OFFSET_BITS{1'b0}}),
                 sum_q.any_digit, overflowed};

endmodule

// ----- hdl/string_to_integer_parser.sv -----
// Top level of the string to integer parser: registers, queues and stages.
// Depends on s2i_pkg, s2i_front, s2i_queue, s2i_back, s2i_finish and the defines header.
//
//   channel   direction  handshake             word
//   input     in         push / full           ch, last
//   result    out        pop / empty           value, end_offset, found_digits, overflowed
//   config    in         cfg_write             cfg_index, cfg_data
//
// One character is taken every cycle while the result stage is not holding;
// the parse engine does one radix multiply-add per character, which sets that rate.
// A result passes through the result stage register and the result queue to the output ports.
// Reset clears the registers to base 10 unsigned and empties both queues.
// A stalled result side holds the parse engine; the character queue absorbs it until it is full.
`include "string_to_integer_parser_defines.svh"

module string_to_integer_parser #(
  parameter int OFFSET_BITS = s2i_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [s2i_pkg::CH_W-1:0]       ch,
  input  logic                           last,
  output logic                           empty,
  input  logic                           pop,
  output logic [s2i_pkg::VALUE_W-1:0]    value,
  output logic [OFFSET_BITS-1:0]         end_offset,
  output logic                           found_digits,
  output logic                           overflowed,
  input  logic                           cfg_write,
  input  logic [s2i_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [s2i_pkg::CFG_DATA_W-1:0] cfg_data
);
  import s2i_pkg::*;

  localparam int CLS_W = $bits(class_t);
  localparam int OUT_W = VALUE_W + OFFSET_BITS + 2;

  logic [BASE_W-1:0]      number_base;
  logic                   signed_mode;
  class_t                 front_cls;
  logic [CLS_W-1:0]       mid_rdata;
  logic                   mid_empty;
  logic                   back_take;
  logic                   back_done;
  summary_t               back_sum;
  logic [OFFSET_BITS-1:0] back_end;
  logic                   fin_hold;
  logic                   fin_push;
  logic [OUT_W-1:0]       fin_word;
  logic                   out_full;
  logic [OUT_W-1:0]       out_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
      signed_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUMBER_BASE: number_base <= cfg_data;
        REG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front end and the character queue.
  s2i_front u_front (
    .ch   (ch),
    .last (last),
    .cls  (front_cls)
  );

  s2i_queue #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cls),
    .full  (full),
    .pop   (back_take),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  // Parse engine.
  s2i_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .valid       (!mid_empty),
    .cls         (class_t'(mid_rdata)),
    .stall       (fin_hold),
    .number_base (number_base),
    .signed_mode (signed_mode),
    .take        (back_take),
    .done        (back_done),
    .summary     (back_sum),
    .end_pos     (back_end)
  );

  // Result stage and result queue.
  s2i_finish #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_finish (
    .clk      (clk),
    .rst      (rst),
    .load     (back_done),
    .summary  (back_sum),
    .end_pos  (back_end),
    .out_full (out_full),
    .hold     (fin_hold),
    .push     (fin_push),
    .word     (fin_word)
  );

  s2i_queue #(
    .WIDTH (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fin_push),
    .wdata (fin_word),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign value        = out_rdata[OUT_W-1 -: VALUE_W];
  assign end_offset   = out_rdata[OFFSET_BITS+1:2];
  assign found_digits = out_rdata[1];
  assign overflowed   = out_rdata[0];

  // A word with no digits is all zero.
  `S2I_ASSERT_IMPL(a_no_digit_zero, !empty && !found_digits, (value == '0) && (end_offset == '0) && !overflowed, "result without digits is not zero")
  // Overflow only ever comes with digits.
  `S2I_ASSERT_IMPL(a_ovf_has_digits, !empty && overflowed, found_digits, "overflow reported without digits")
  // A held result is not lost while the result queue is full.
  `S2I_ASSERT_NEXT(a_hold_keeps, fin_hold, fin_hold || fin_push, "held result dropped")
  // The parse engine never takes a character while the result stage holds.
  `S2I_ASSERT_IMPL(a_no_take_on_hold, fin_hold, !back_take, "character taken while result held")

endmodule

// ----- verif/string_to_integer_parser_tb.sv -----
// Self-checking testbench for string_to_integer_parser: directed and random strings
// are fed one character per word and each result is checked against a local predictor.
// Depends on s2i_pkg and the string_to_integer_parser RTL.
module string_to_integer_parser_tb;
  import s2i_pkg::*;

  localparam int          OFF_W        = OFFSET_BITS_DEF;
  localparam logic [OFF_W-1:0] OFFSET_MAX = {OFF_W{1'b1}};
  localparam int unsigned NOT_A_DIGIT  = 99;
  localparam int          QUIET_CYCLES = 8;
  localparam int          RANDOM_CHARS = 400;
  localparam int          LONG_SPACES  = 40;
  localparam int          TIME_LIMIT   = 4_000_000;

  // Expected contents of one result word.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [OFF_W-1:0]   end_offset;
    logic               found_digits;
    logic               overflowed;
  } parse_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic [CH_W-1:0]        ch;
  logic                   last;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [VALUE_W-1:0]     value;
  logic [OFF_W-1:0]       end_offset;
  logic                   found_digits;
  logic                   overflowed;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Local copy of the registers and of the per-string parse state.
  logic [BASE_W-1:0]  base_reg   = BASE_RESET;
  logic               signed_reg = 1'b0;
  phase_t             str_phase;
  logic               str_negative;
  logic [VALUE_W-1:0] str_magnitude;
  logic [BASE_W-1:0]  str_radix;
  logic [OFF_W-1:0]   str_position;
  logic [OFF_W-1:0]   str_digit_end;
  logic               str_saturated;
  logic               str_has_digit;

  parse_result_t awaited_results[$];
  int            mismatch_count = 0;
  int            results_seen   = 0;
  int            chars_sent     = 0;
  bit            steady         = 1'b0;
  int            pop_hold       = 0;

  string_to_integer_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .ch           (ch),
    .last         (last),
    .empty        (empty),
    .pop          (pop),
    .value        (value),
    .end_offset   (end_offset),
    .found_digits (found_digits),
    .overflowed   (overflowed),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Value of an alphanumeric character as a digit, or NOT_A_DIGIT.
  function automatic int unsigned digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 10;
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    return NOT_A_DIGIT;
  endfunction

  function automatic void clear_string();
    str_phase     = PH_SPACE;
    str_negative  = 1'b0;
    str_magnitude = '0;
    str_radix     = '0;
    str_position  = '0;
    str_digit_end = '0;
    str_saturated = 1'b0;
    str_has_digit = 1'b0;
  endfunction

  // Multiply-add one digit into the magnitude, pinning it at all ones on overflow.
  function automatic void add_digit(int unsigned d);
    logic [VALUE_W-1:0] radix;
    radix = (str_radix < 2) ? 64'd2 : 64'(str_radix);
    if (str_magnitude > (ALL_ONES - 64'(d)) / radix) begin
      str_magnitude = ALL_ONES;
      str_saturated = 1'b1;
    end else begin
      str_magnitude = str_magnitude * radix + 64'(d);
    end
    str_has_digit = 1'b1;
    str_digit_end = str_position;
  endfunction

  function automatic void digit_or_stop(logic [7:0] c);
    int unsigned d;
    d = digit_of(c);
    if (d < str_radix) add_digit(d);
    else str_phase = PH_DONE;
  endfunction

  // First character after whitespace and sign: fixes the radix for this string.
  function automatic void begin_number(logic [7:0] c);
    logic [BASE_W-1:0] b;
    b = base_reg;
    if (b == BAD_BASE || b > MAX_BASE) begin
      str_phase = PH_DONE;
    end else if ((b == AUTO_BASE || b == HEX_BASE) && c == "0") begin
      str_radix     = (b == AUTO_BASE) ? OCT_BASE : HEX_BASE;
      str_has_digit = 1'b1;
      str_digit_end = str_position;
      str_phase     = PH_ZERO;
    end else begin
      str_radix = (b == AUTO_BASE) ? DEC_BASE : b;
      str_phase = PH_DIGITS;
      digit_or_stop(c);
    end
  endfunction

  // Advance the parse by one accepted character; a closing character queues a result.
  function automatic void parse_char(logic [7:0] c, logic is_last);
    parse_result_t r;
    if (str_position < OFFSET_MAX) str_position++;
    case (str_phase)
      PH_SPACE: begin
        if (c == "-") begin
          str_negative = 1'b1;
          str_phase    = PH_SIGN;
        end else if (c == "+") begin
          str_phase = PH_SIGN;
        end else if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
          begin_number(c);
        end
      end
      PH_SIGN: begin_number(c);
      PH_ZERO: begin
        if (c == "x" || c == "X") begin
          str_radix = HEX_BASE;
          str_phase = PH_XPFX;
        end else begin
          str_phase = PH_DIGITS;
          digit_or_stop(c);
        end
      end
      PH_XPFX: begin
        if (digit_of(c) < 16) begin
          str_phase = PH_DIGITS;
          add_digit(digit_of(c));
        end else begin
          str_phase = PH_DONE;
        end
      end
      PH_DIGITS: digit_or_stop(c);
      default: ;
    endcase
    if (!is_last) return;

    // Signed mode clamps on the magnitude; unsigned overflow gives all ones.
    r.overflowed = 1'b0;
    if (!str_has_digit) begin
      r.value = '0;
    end else if (signed_reg) begin
      if (str_negative) begin
        if (str_saturated || str_magnitude > NEG_LIMIT) begin
          r.value      = NEG_LIMIT;
          r.overflowed = 1'b1;
        end else begin
          r.value = ~str_magnitude + 64'd1;
        end
      end else if (str_saturated || str_magnitude > POS_LIMIT) begin
        r.value      = POS_LIMIT;
        r.overflowed = 1'b1;
      end else begin
        r.value = str_magnitude;
      end
    end else if (str_saturated) begin
      r.value      = ALL_ONES;
      r.overflowed = 1'b1;
    end else begin
      r.value = str_negative ? ~str_magnitude + 64'd1 : str_magnitude;
    end
    r.end_offset   = str_has_digit ? str_digit_end : '0;
    r.found_digits = str_has_digit;
    awaited_results.push_back(r);
    clear_string();
  endfunction

  // Offer one character word, wait until it is taken, then predict its effect.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    if (!steady && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    push <= 1'b1;
    ch   <= c;
    last <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    parse_char(c, is_last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Hold the input side until every expected word has come and the pipeline is empty.
  task automatic wait_idle();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_NUMBER_BASE: base_reg = data;
      REG_SIGNED_MODE: signed_reg = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [BASE_W-1:0] b, input logic s);
    wait_idle();
    write_register(REG_NUMBER_BASE, b);
    write_register(REG_SIGNED_MODE, {5'($urandom_range(0, 31)), s});
  endtask

  // Decimal parsing, unsigned: whitespace, signs, full range, overflow, junk.
  task automatic test_decimal();
    configure(DEC_BASE, 1'b0);
    send_string("42");
    send_string("  -42");
    send_string("+7");
    send_string("18446744073709551615");
    send_string("18446744073709551616");
    send_string("12xyz");
    send_string("abc");
    send_string("-");
    for (int k = 9; k <= 13; k++) send_char(8'(k), 1'b0);
    send_char(" ", 1'b0);
    send_char("9", 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  // Signed mode: both limits exactly, one past each, and a saturated magnitude.
  task automatic test_signed_clamp();
    configure(DEC_BASE, 1'b1);
    send_string("9223372036854775807");
    send_string("9223372036854775808");
    send_string("-9223372036854775808");
    send_string("-9223372036854775809");
    send_string("-99999999999999999999");
    send_string("-17");
  endtask

  // Radix taken from the prefix, including a hex prefix with no hex digit.
  task automatic test_auto_base();
    configure(AUTO_BASE, 1'b0);
    send_string("0x1F");
    send_string("0XfF");
    send_string("0x");
    send_string("0xg");
    send_string("017");
    send_string("089");
    send_string("0");
    send_string("123");
    send_string("-0x10");
  endtask

  task automatic test_other_bases();
    configure(HEX_BASE, 1'b0);
    send_string("0xff");
    send_string("0x");
    send_string("Ff");
    configure(MAX_BASE, 1'b0);
    send_string("zZ");
    send_string("Z0");
    configure(BASE_W'(2), 1'b0);
    send_string("1012");
    configure(HEX_BASE, 1'b1);
    send_string("-8000000000000000");
    send_string("ffffffffffffffff");
  endtask

  // A radix of one or above 36 converts nothing.
  task automatic test_invalid_base();
    configure(BAD_BASE, 1'b0);
    send_string("11");
    configure(BASE_W'(37), 1'b1);
    send_string("5");
    configure(BASE_W'(63), 1'b0);
    send_string("zz");
  endtask

  // A long run of leading whitespace in front of a long number, with no gaps.
  task automatic test_long_string();
    configure(DEC_BASE, 1'b0);
    steady = 1'b1;
    repeat (LONG_SPACES) send_char(" ", 1'b0);
    send_string("12345678901234");
    steady = 1'b0;
  endtask

  // One random string: mostly well formed with random content, some broken or noise.
  task automatic send_random_string();
    logic [7:0]  text[$];
    int unsigned radix, d, n, ws;
    text = {};
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        ws = $urandom_range(8, 13);
        text.push_back(ws == 8 ? " " : 8'(ws));
      end
      case ($urandom_range(0, 3))
        0: text.push_back("-");
        1: text.push_back("+");
        default: ;
      endcase
      radix = (base_reg >= 2 && base_reg <= MAX_BASE) ? base_reg : 10;
      if (base_reg == AUTO_BASE) begin
        case ($urandom_range(0, 2))
          0: begin
            text.push_back("0");
            text.push_back($urandom_range(0, 1) ? "x" : "X");
            radix = 16;
          end
          1: begin
            text.push_back("0");
            radix = 8;
          end
          default: radix = 10;
        endcase
      end else if (base_reg == HEX_BASE && $urandom_range(0, 2) == 0) begin
        text.push_back("0");
        text.push_back("x");
      end
      if ($urandom_range(0, 9) == 0) n = 0;
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(10, 70);
      else n = $urandom_range(1, 6);
      repeat (n) begin
        d = $urandom_range(0, radix - 1);
        if (d < 10) text.push_back(8'("0" + d));
        else if ($urandom_range(0, 1)) text.push_back(8'("a" + d - 10));
        else text.push_back(8'("A" + d - 10));
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
      end
      if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  // Batches of random strings, each under a fresh register setting.
  task automatic test_random_strings();
    int               chars_start, results_start;
    logic [BASE_W-1:0] b;
    chars_start   = chars_sent;
    results_start = results_seen;
    while (chars_sent - chars_start < RANDOM_CHARS || results_seen - results_start < 48) begin
      if (chars_sent - chars_start > RANDOM_CHARS * 4 / 5) steady = 1'b1;
      case ($urandom_range(0, 9))
        0: b = AUTO_BASE;
        1: b = BASE_W'(2);
        2: b = OCT_BASE;
        3: b = DEC_BASE;
        4: b = HEX_BASE;
        5: b = MAX_BASE;
        6: b = BAD_BASE;
        7: b = BASE_W'($urandom_range(37, 63));
        default: b = BASE_W'($urandom_range(2, 36));
      endcase
      configure(b, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(4, 10)) send_random_string();
    end
  endtask

  // Result side: pop stalls in short random bursts.
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      pop_hold = $urandom_range(0, 4);
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result word: value %h", value);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (value !== want.value) begin
          $error("value: expected %h, got %h", want.value, value);
          mismatch_count++;
        end
        if (end_offset !== want.end_offset) begin
          $error("end_offset: expected %0d, got %0d", want.end_offset, end_offset);
          mismatch_count++;
        end
        if (found_digits !== want.found_digits) begin
          $error("found_digits: expected %b, got %b", want.found_digits, found_digits);
          mismatch_count++;
        end
        if (overflowed !== want.overflowed) begin
          $error("overflowed: expected %b, got %b", want.overflowed, overflowed);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #(TIME_LIMIT);
    $display("string_to_integer_parser_tb failed");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    ch        = '0;
    last      = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    clear_string();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_decimal();
    test_signed_clamp();
    test_auto_base();
    test_other_bases();
    test_invalid_base();
    test_long_string();
    test_random_strings();

    // Drain, then allow for the pipeline latency before deciding.
    push <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("string_to_integer_parser_tb passed");
    end else begin
      $display("string_to_integer_parser_tb failed");
    end
    $finish;
  end

endmodule

// ----- string_to_integer_parser.f -----
+incdir+hdl
hdl/s2i_pkg.sv
hdl/s2i_queue.sv
hdl/s2i_front.sv
hdl/s2i_back.sv
hdl/s2i_finish.sv
hdl/string_to_integer_parser.sv
verif/string_to_integer_parser_tb.sv
